/* rtl/mexp_pkg.sv */
`default_nettype none

package mexp_pkg;

    localparam int unsigned RES_W = 30;
    localparam int unsigned EXP_W = 63;
    localparam int unsigned BASE_W = 64;
    localparam int unsigned HI_W = BASE_W - RES_W;
    localparam int unsigned X_W = 2 * RES_W;

    localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [31:0] MODULUS_X2 = 32'd2000000014;
    // 2^30 mod p, folds the upper part of the base onto the lower
    localparam logic [RES_W-1:0] FOLD_30 = 30'd73741817;
    // barrett factor floor(2^60 / p)
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

    localparam logic [1:0] LAST_CNT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_HI,
        ST_RED_LO,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_RED_HI,
        OP_RED_LO,
        OP_STEP
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic cap_hi;
        logic cap_lo;
        logic cap_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_last;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/mexp_mulmod.sv */
`default_nettype none

module mexp_mulmod (
    input  wire logic                         clk,
    input  wire logic [mexp_pkg::RES_W-1:0]   a,
    input  wire logic [mexp_pkg::RES_W-1:0]   b,
    input  wire logic [mexp_pkg::HI_W-1:0]    addend,
    output logic      [mexp_pkg::RES_W-1:0]   r
);
    import mexp_pkg::*;

    logic [X_W-1:0] ab;
    logic [X_W-1:0] x_next;
    logic [X_W-1:0] x_reg;
    logic [61:0]    qm;
    logic [30:0]    q_reg;
    logic [31:0]    xlo1_reg;
    logic [31:0]    qpm;
    logic [31:0]    qp_reg;
    logic [31:0]    xlo2_reg;
    logic [31:0]    r0;
    logic [32:0]    t1;
    logic [32:0]    t2;

    assign ab = a * b;
    assign x_next = ab + X_W'(addend);

    // quotient estimate, at most two short of the true one
    assign qm = x_reg[X_W-1:29] * BARRETT_MU;
    assign qpm = 32'(q_reg) * 32'(MODULUS);

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        q_reg    <= qm[61:31];
        xlo1_reg <= x_reg[31:0];
        qp_reg   <= qpm;
        xlo2_reg <= xlo1_reg;
    end

    // remainder is below 3p, so 32 bits hold it exactly
    assign r0 = xlo2_reg - qp_reg;
    assign t1 = {1'b0, r0} - {1'b0, 32'(MODULUS)};
    assign t2 = {1'b0, r0} - {1'b0, MODULUS_X2};

    always_comb
    begin
        if (!t2[32])
            r = t2[RES_W-1:0];
        else if (!t1[32])
            r = t1[RES_W-1:0];
        else
            r = r0[RES_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/mexp_datapath.sv */
`default_nettype none

module mexp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mexp_pkg::cmd_t                cmd,
    output mexp_pkg::sts_t                     sts,
    input  wire logic [mexp_pkg::BASE_W-1:0]   base,
    input  wire logic [mexp_pkg::EXP_W-1:0]    exponent,
    output logic      [mexp_pkg::RES_W-1:0]    power_mod
);
    import mexp_pkg::*;

    logic              neg_reg;
    logic [BASE_W-1:0] mag_reg;
    logic [EXP_W-1:0]  exp_reg;
    logic [RES_W-1:0]  sq_reg;
    logic [RES_W-1:0]  acc_reg;
    logic [RES_W-1:0]  pm_reg;

    logic [RES_W-1:0]  sq_a;
    logic [RES_W-1:0]  sq_b;
    logic [HI_W-1:0]   sq_add;
    logic [RES_W-1:0]  sq_res;
    logic [RES_W-1:0]  acc_res;
    logic [RES_W-1:0]  base_res;

    always_comb
    begin
        unique case (cmd.op)
            OP_RED_HI:
            begin
                sq_a   = '0;
                sq_b   = '0;
                sq_add = mag_reg[BASE_W-1:RES_W];
            end
            OP_RED_LO:
            begin
                sq_a   = sq_reg;
                sq_b   = FOLD_30;
                sq_add = HI_W'(mag_reg[RES_W-1:0]);
            end
            default:
            begin
                sq_a   = sq_reg;
                sq_b   = sq_reg;
                sq_add = '0;
            end
        endcase
    end

    mexp_mulmod u_sq_lane (
        .clk    (clk),
        .a      (sq_a),
        .b      (sq_b),
        .addend (sq_add),
        .r      (sq_res)
    );

    mexp_mulmod u_acc_lane (
        .clk    (clk),
        .a      (acc_reg),
        .b      (sq_reg),
        .addend ('0),
        .r      (acc_res)
    );

    // negative base: lift a nonzero remainder of the magnitude
    assign base_res = (neg_reg && (sq_res != '0)) ? (MODULUS - sq_res) : sq_res;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= base[BASE_W-1];
            mag_reg <= base[BASE_W-1] ? (~base + BASE_W'(1)) : base;
            exp_reg <= exponent;
        end
        else if (cmd.cap_step)
        begin
            exp_reg <= exp_reg >> 1;
        end

        if (cmd.cap_hi)
            sq_reg <= sq_res;
        else if (cmd.cap_lo)
            sq_reg <= base_res;
        else if (cmd.cap_step)
            sq_reg <= sq_res;

        if (cmd.cap_lo)
            acc_reg <= RES_W'(1);
        else if (cmd.cap_step && exp_reg[0])
            acc_reg <= acc_res;

        if (cmd.emit)
            pm_reg <= acc_reg;
    end

    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_last = (exp_reg[EXP_W-1:1] == '0);
    assign power_mod = pm_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_step |=> (sq_reg < MODULUS) && (acc_reg < MODULUS))
        else $error("square or accumulator left the residue range");

    a_exp_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_step |=> exp_reg == ($past(exp_reg) >> 1))
        else $error("exponent did not advance by one bit");

    a_acc_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap_lo |=> (acc_reg == RES_W'(1)) && (sq_reg < MODULUS))
        else $error("bad start of the exponent scan");

endmodule

`default_nettype wire

/* rtl/mexp_ctrl.sv */
`default_nettype none

module mexp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output mexp_pkg::cmd_t       cmd,
    input  wire mexp_pkg::sts_t  sts
);
    import mexp_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       last;

    assign last = (cnt_reg == LAST_CNT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RED_HI;
            end
            ST_RED_HI:
            begin
                if (last)
                    state_next = ST_RED_LO;
            end
            ST_RED_LO:
            begin
                if (last)
                    state_next = sts.exp_zero ? ST_DONE : ST_STEP;
            end
            ST_STEP:
            begin
                if (last && sts.exp_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '{load: 1'b0, op: OP_STEP, cap_hi: 1'b0, cap_lo: 1'b0,
                cap_step: 1'b0, emit: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_RED_HI:
            begin
                cmd.op     = OP_RED_HI;
                cmd.cap_hi = last;
            end
            ST_RED_LO:
            begin
                cmd.op     = OP_RED_LO;
                cmd.cap_lo = last;
            end
            ST_STEP:
            begin
                cmd.op       = OP_STEP;
                cmd.cap_step = last;
            end
            ST_DONE:
            begin
                cmd.emit = !out_valid_reg || !out_stall;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    // pass counter wraps to zero after the capture cycle
    assign cnt_next = ((state_reg == ST_IDLE) || (state_reg == ST_DONE)) ?
                      2'd0 : cnt_reg + 2'd1;
    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_RED_HI) && (cnt_reg == 2'd0))
        else $error("accepted item did not start the reduction");

    a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after emit");

    a_lo_after_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED_LO) |->
            ($past(state_reg) == ST_RED_HI) || ($past(state_reg) == ST_RED_LO))
        else $error("low fold entered out of order");

endmodule

`default_nettype wire

/* rtl/modular_exponentiation.sv */
// channel  signals                           item
// in       in_valid / in_stall               base (s64), exponent (u63)
// out      out_valid / out_stall             power_mod (u30)
//
// each exponent bit is one pass of two 3-multiplier barrett lanes
// reset clears the controller and the output valid only
// in_stall is high from accept until the result is loaded into the output register
// a stalled result holds the next item only at its own end, not at accept
`default_nettype none

module modular_exponentiation (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mexp_pkg::BASE_W-1:0]   base,
    input  wire logic [mexp_pkg::EXP_W-1:0]    exponent,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [mexp_pkg::RES_W-1:0]    power_mod
);
    import mexp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    mexp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .base      (base),
        .exponent  (exponent),
        .power_mod (power_mod)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] PRIME = 64'd1000000007;
    localparam int CYCLE_LIMIT = 1200000;
    localparam int RANDOM_ITEMS = 730;

    typedef struct {
        logic [mexp_pkg::BASE_W-1:0] base;
        logic [mexp_pkg::EXP_W-1:0]  exponent;
    } job_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [mexp_pkg::BASE_W-1:0] base = '0;
    logic [mexp_pkg::EXP_W-1:0]  exponent = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [mexp_pkg::RES_W-1:0]  power_mod;

    job_t                       jobs[$];
    logic [mexp_pkg::RES_W-1:0] powers_due[$];

    int errors = 0;
    int sent = 0;
    int received = 0;
    int cycles = 0;
    logic [3:0] idle_left = '0;
    logic [3:0] hold_left = '0;

    modular_exponentiation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .power_mod (power_mod)
    );

    always #5 clk = ~clk;

    // base^exponent mod p, right-to-left square and multiply
    function automatic logic [mexp_pkg::RES_W-1:0] power_of(
        logic [mexp_pkg::BASE_W-1:0] b, logic [mexp_pkg::EXP_W-1:0] e);
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] acc;
        if (b[63])
        begin
            mag = ~b + 64'd1;
            sq = mag % PRIME;
            if (sq != 64'd0)
                sq = PRIME - sq;
        end
        else
            sq = b % PRIME;
        acc = 64'd1;
        for (int i = 0; i < mexp_pkg::EXP_W; i++)
        begin
            if (e[i])
                acc = (acc * sq) % PRIME;
            sq = (sq * sq) % PRIME;
        end
        return acc[mexp_pkg::RES_W-1:0];
    endfunction

    // in groups of 40 items, one group in three has no idling, the others idle at random
    function automatic logic [3:0] draw_wait(int count, int quiet_phase);
        if ((count / 40) % 3 == quiet_phase)
            return 4'd0;
        return 4'($urandom_range(0, 9));
    endfunction

    task automatic add_job(logic [63:0] b, logic [62:0] e);
        job_t j;
        j.base = b;
        j.exponent = e;
        jobs.insert(jobs.size(), j);
    endtask

    function automatic logic [63:0] random_base();
        logic [63:0] v;
        logic [63:0] k;
        case ($urandom_range(0, 9))
            5: v = 64'($signed($urandom_range(0, 40)) - 20);
            6:
            begin
                k = 64'($urandom) << $urandom_range(0, 1);
                v = k * PRIME + 64'($signed($urandom_range(0, 4)) - 2);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 64'd1;
            end
            7:
            begin
                v = PRIME + 64'($signed($urandom_range(0, 2)) - 1);
                if ($urandom_range(0, 1) == 1)
                    v = ~v + 64'd1;
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0: v = 64'h8000_0000_0000_0000;
                    1: v = 64'h7fff_ffff_ffff_ffff;
                    2: v = 64'hffff_ffff_ffff_ffff;
                    default: v = 64'd0;
                endcase
            end
            9: v = 64'($signed($urandom));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [62:0] random_exponent();
        logic [62:0] v;
        case ($urandom_range(0, 9))
            6: v = 63'($urandom_range(0, 20));
            7: v = 63'({$urandom, $urandom} >> $urandom_range(0, 62));
            8: v = 63'd1 << $urandom_range(0, 62);
            9: v = '1;
            default: v = 63'({$urandom, $urandom});
        endcase
        return v;
    endfunction

    // driver: an accepted item is predicted, then the next one waits its gap
    always @(posedge clk or negedge rst_n)
    begin
        logic [3:0] gap;
        job_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            base <= '0;
            exponent <= '0;
            idle_left <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            gap = idle_left;
            if (in_valid)
            begin
                powers_due.insert(powers_due.size(), power_of(base, exponent));
                sent++;
                gap = draw_wait(sent, 1);
            end
            if (gap != 4'd0 || jobs.size() == 0)
            begin
                in_valid <= 1'b0;
                idle_left <= (gap != 4'd0) ? gap - 4'd1 : 4'd0;
            end
            else
            begin
                nxt = jobs.pop_front();
                base <= nxt.base;
                exponent <= nxt.exponent;
                in_valid <= 1'b1;
                idle_left <= 4'd0;
            end
        end
    end

    // monitor: compare each accepted result, then stall the next one a while
    always @(posedge clk or negedge rst_n)
    begin
        logic [mexp_pkg::RES_W-1:0] want;
        logic [3:0] hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= '0;
        end
        else if (out_valid === 1'b1 && !out_stall)
        begin
            if (powers_due.size() == 0)
            begin
                $display("%0t: unexpected item, power_mod %0d", $time, power_mod);
                errors++;
            end
            else
            begin
                want = powers_due.pop_front();
                if (power_mod !== want)
                begin
                    $display("%0t: power_mod expected %0d actual %0d", $time, want, power_mod);
                    errors++;
                end
            end
            received++;
            hold = draw_wait(received, 2);
            out_stall <= (hold != 4'd0);
            hold_left <= hold;
        end
        else if (out_valid === 1'b1 && hold_left != 4'd0)
        begin
            hold_left <= hold_left - 4'd1;
            out_stall <= (hold_left > 4'd1);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        // zero exponent, also with base a multiple of p
        add_job(64'd0, 63'd0);
        add_job(PRIME, 63'd0);
        add_job(64'd12345, 63'd0);
        add_job(64'hffff_ffff_ffff_ffff, 63'd0);
        // base a multiple of p with nonzero exponent
        add_job(64'd0, 63'd5);
        add_job(PRIME, 63'd7);
        add_job(~PRIME + 64'd1, 63'd3);
        add_job(PRIME * 64'd9000000000, '1);
        // most negative and most positive base, then other corner bases and exponents
        add_job(64'h8000_0000_0000_0000, 63'd1);
        add_job(64'h8000_0000_0000_0000, '1);
        add_job(64'h7fff_ffff_ffff_ffff, 63'd1);
        add_job(64'h7fff_ffff_ffff_ffff, '1);
        add_job(64'hffff_ffff_ffff_ffff, 63'd1);
        add_job(64'hffff_ffff_ffff_ffff, 63'd2);
        add_job(64'hffff_ffff_ffff_fffe, 63'd5);
        add_job(PRIME - 64'd1, 63'd2);
        add_job(PRIME + 64'd1, 63'h5555_5555_5555_5555);
        add_job(64'd2, 63'd62);
        add_job(64'd2, 63'd1 << 62);
        add_job(64'd1, '1);
        add_job(64'd3, 63'd1000000006);
        add_job(64'd3, 63'h2aaa_aaaa_aaaa_aaaa);
        add_job({$urandom, $urandom}, 63'd1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_job(random_base(), random_exponent());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (jobs.size() != 0 || in_valid)
            @(negedge clk);
        while (powers_due.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
